// ===== rtl/core/ptt_pkg.sv =====
// Shared types and command codes for the pulse trigger timer.
package ptt_pkg;

   localparam int TimeWidth = 32;

   // Command codes carried in the request beat
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_TRIGGER = 2'd1;
   localparam logic [1:0] CMD_WRITE   = 2'd2;
   localparam logic [1:0] CMD_RUN     = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_HIGH_TIME = 2'd0;
   localparam logic [1:0] REG_LOW_TIME  = 2'd1;
   localparam logic [1:0] REG_CONT_MODE = 2'd2;
   localparam logic [1:0] REG_IDLE_LVL  = 2'd3;

   typedef struct packed {
      logic [TimeWidth-1:0] high_time;
      logic [TimeWidth-1:0] low_time;
      logic                 continuous_mode;
      logic                 idle_level;
   } ptt_cfg_type;

   typedef struct packed {
      logic                 out_level;
      logic [TimeWidth-1:0] elapsed_ticks;
      logic                 run_enable;
      logic                 trigger_pending;
   } ptt_state_type;

endpackage

// ===== rtl/core/ptt_csr.sv =====
// Configuration register file of the pulse trigger timer.
module ptt_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output ptt_pkg::ptt_cfg_type cfg
);
   import ptt_pkg::*;

   ptt_cfg_type cfg_ff;
   ptt_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HIGH_TIME: cfg_in.high_time       = csr_wdata[TimeWidth-1:0];
            REG_LOW_TIME:  cfg_in.low_time        = csr_wdata[TimeWidth-1:0];
            REG_CONT_MODE: cfg_in.continuous_mode = csr_wdata[0];
            REG_IDLE_LVL:  cfg_in.idle_level      = csr_wdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/ptt_step.sv =====
// Next-state and result logic for one command of the pulse trigger timer.
module ptt_step (
   input  ptt_pkg::ptt_cfg_type   cfg,
   input  ptt_pkg::ptt_state_type cur,
   input  logic [1:0]             cmd,
   input  logic                   value_bit,
   output ptt_pkg::ptt_state_type nxt,
   output logic                   changed
);
   import ptt_pkg::*;

   logic [TimeWidth-1:0] count_inc;
   logic [TimeWidth-1:0] limit;
   logic                 at_idle;
   logic                 expired;

   // Saturating increment, then compare against the time for the current phase
   assign count_inc = (&cur.elapsed_ticks) ? cur.elapsed_ticks
                                           : cur.elapsed_ticks + 1'b1;
   assign at_idle   = (cur.out_level == cfg.idle_level);
   assign limit     = cfg.continuous_mode ? (cur.out_level ? cfg.high_time : cfg.low_time)
                                          : (cfg.idle_level ? cfg.high_time : cfg.low_time);
   assign expired   = (count_inc >= limit);

   always_comb begin
      nxt     = cur;
      changed = 1'b0;
      unique case (cmd)
         CMD_TICK: begin
            nxt.elapsed_ticks = count_inc;
            if (cfg.continuous_mode) begin
               // halted at idle while run is off
               if (!(at_idle && !cur.run_enable) && expired) begin
                  nxt.out_level     = ~cur.out_level;
                  nxt.elapsed_ticks = '0;
                  changed           = 1'b1;
               end
            end else if (!at_idle) begin
               if (expired) begin
                  nxt.out_level     = cfg.idle_level;
                  nxt.elapsed_ticks = '0;
                  changed           = 1'b1;
               end
            end else if (cur.trigger_pending) begin
               nxt.out_level       = ~cfg.idle_level;
               nxt.trigger_pending = 1'b0;
               nxt.elapsed_ticks   = '0;
               changed             = 1'b1;
            end
         end
         CMD_TRIGGER: nxt.trigger_pending = 1'b1;
         CMD_WRITE:   nxt.out_level       = value_bit;
         CMD_RUN:     nxt.run_enable      = value_bit;
         default:     nxt = cur;
      endcase
   end

endmodule

// ===== rtl/core/pulse_trigger_timer.sv =====
// Top level of the pulse trigger timer: input stage, state update, result stage.
//
//   channel  direction  beat contents
//   req      in         tuser[1:0] cmd; tdata[0] value_bit
//   rsp      out        tdata[0] pin_level, tdata[1] changed
//   csr      in         csr_index register, csr_wdata value; always ready
//
// One beat per cycle sustained while rsp_tready is high.
// The step from the input register to the result register is a single 32-bit
// increment and compare. Reset clears state and configuration to zero.
// A stalled response holds one beat in the input register, then req_tready drops.
module pulse_trigger_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] value_bit, [7:1] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] pin_level, [1] changed, [7:2] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ptt_pkg::*;

   ptt_cfg_type   cfg;
   ptt_state_type state_ff;
   ptt_state_type state_in;
   ptt_state_type state_nxt;

   logic       in_vld_ff;
   logic [1:0] in_cmd_ff;
   logic       in_bit_ff;
   logic       out_vld_ff;
   logic       out_lvl_ff;
   logic       out_chg_ff;
   logic       step_chg;
   logic       advance;

   assign csr_ready = 1'b1;

   ptt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptt_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .cmd       (in_cmd_ff),
      .value_bit (in_bit_ff),
      .nxt       (state_nxt),
      .changed   (step_chg)
   );

   // staged beat moves on when the result slot is free or draining
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign state_in   = advance ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_bit_ff <= req_tdata[0];
      end
      if (advance) begin
         out_lvl_ff <= state_nxt.out_level;
         out_chg_ff <= step_chg;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b0, out_chg_ff, out_lvl_ff};

`ifndef SYNTHESIS
   a_change_flips_level: assert property (@(posedge clock) disable iff (reset)
      advance && step_chg |=> state_ff.out_level != $past(state_ff.out_level))
      else $error("timed change did not flip the level");

   a_change_clears_count: assert property (@(posedge clock) disable iff (reset)
      advance && step_chg |=> state_ff.elapsed_ticks == '0)
      else $error("elapsed count not cleared on timed change");

   a_trigger_latched: assert property (@(posedge clock) disable iff (reset)
      advance && in_cmd_ff == CMD_TRIGGER |=> state_ff.trigger_pending)
      else $error("trigger not latched");

   a_staged_beat_kept: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_cmd_ff) && $stable(in_bit_ff))
      else $error("staged beat lost while result stalled");

   a_state_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> state_ff == $past(state_ff))
      else $error("state changed without a beat");
`endif

endmodule

// ===== test/tb_pulse_trigger_timer.sv =====
// Self-checking testbench for the pulse trigger timer: directed and random command streams.
module tb_pulse_trigger_timer;
   timeunit 1ns;
   timeprecision 1ps;

   import ptt_pkg::*;

   localparam int StallLimit = 2000;

   typedef struct packed {
      logic pin_level;
      logic changed;
   } pin_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] value_bit, [7:1] zero
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] pin_level, [1] changed, [7:2] zero
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   // timer model: configuration and state as the block should hold them
   ptt_cfg_type   timer_cfg;
   ptt_state_type timer_st;
   pin_beat_type  pending_pins[$];

   int  mismatches;
   int  quiet_cycles;
   logic calm;   // when set neither side idles

   pulse_trigger_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Next level for one command; updates the model state.
   function automatic pin_beat_type advance_timer(input logic [1:0] cmd, input logic lvl);
      pin_beat_type res;
      logic [31:0]  limit;
      res.changed = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (timer_st.elapsed_ticks != '1)
               timer_st.elapsed_ticks = timer_st.elapsed_ticks + 32'd1;
            if (timer_cfg.continuous_mode) begin
               // halted once resting at idle with run disabled
               if (!(timer_st.out_level == timer_cfg.idle_level && !timer_st.run_enable)) begin
                  limit = timer_st.out_level ? timer_cfg.high_time : timer_cfg.low_time;
                  if (timer_st.elapsed_ticks >= limit) begin
                     timer_st.out_level     = ~timer_st.out_level;
                     timer_st.elapsed_ticks = '0;
                     res.changed            = 1'b1;
                  end
               end
            end else if (timer_st.out_level != timer_cfg.idle_level) begin
               limit = timer_cfg.idle_level ? timer_cfg.high_time : timer_cfg.low_time;
               if (timer_st.elapsed_ticks >= limit) begin
                  timer_st.out_level     = timer_cfg.idle_level;
                  timer_st.elapsed_ticks = '0;
                  res.changed            = 1'b1;
               end
            end else if (timer_st.trigger_pending) begin
               timer_st.out_level       = ~timer_cfg.idle_level;
               timer_st.trigger_pending = 1'b0;
               timer_st.elapsed_ticks   = '0;
               res.changed              = 1'b1;
            end
         end
         CMD_TRIGGER: timer_st.trigger_pending = 1'b1;
         CMD_WRITE:   timer_st.out_level = lvl;
         default:     timer_st.run_enable = lvl;
      endcase
      res.pin_level = timer_st.out_level;
      return res;
   endfunction

   task automatic send_cmd(input logic [1:0] cmd, input logic lvl);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
      pending_pins.push_back(advance_timer(cmd, lvl));
   endtask

   task automatic send_random_cmd();
      int pick;
      pick = $urandom_range(99);
      if (pick < 62)
         send_cmd(CMD_TICK, 1'($urandom_range(1)));
      else if (pick < 75)
         send_cmd(CMD_TRIGGER, 1'($urandom_range(1)));
      else if (pick < 87)
         send_cmd(CMD_WRITE, 1'($urandom_range(1)));
      else
         send_cmd(CMD_RUN, 1'($urandom_range(1)));
   endtask

   // Sender holds off until every response is back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_HIGH_TIME: timer_cfg.high_time       = val;
         REG_LOW_TIME:  timer_cfg.low_time        = val;
         REG_CONT_MODE: timer_cfg.continuous_mode = val[0];
         default:       timer_cfg.idle_level      = val[0];
      endcase
   endtask

   task automatic program_timer(input logic [31:0] high_t, input logic [31:0] low_t,
                                input logic cont, input logic idle);
      wait_drained();
      write_reg(REG_HIGH_TIME, high_t);
      write_reg(REG_LOW_TIME, low_t);
      write_reg(REG_CONT_MODE, {31'd0, cont});
      write_reg(REG_IDLE_LVL, {31'd0, idle});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_period();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return '1;
      if (pick == 1) return $urandom();
      if (pick == 2) return '0;
      return 32'($urandom_range(6));
   endfunction

   // With all times zero a trigger pulses for exactly one tick.
   task automatic test_reset_state();
      send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_TRIGGER, 1'b0);
      send_cmd(CMD_TICK, 1'b1);
      send_cmd(CMD_TICK, 1'b0);
   endtask

   task automatic test_one_shot();
      program_timer(32'd2, 32'd3, 1'b0, 1'b0);
      send_cmd(CMD_TRIGGER, 1'b1);
      repeat (4) send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_RUN, 1'b1);
      // idle high: pulse goes low and returns after high_time
      program_timer(32'd2, 32'd3, 1'b0, 1'b1);
      send_cmd(CMD_WRITE, 1'b1);
      send_cmd(CMD_TRIGGER, 1'b0);
      repeat (3) send_cmd(CMD_TICK, 1'b1);
   endtask

   task automatic test_continuous();
      program_timer(32'd1, 32'd2, 1'b1, 1'b0);
      send_cmd(CMD_RUN, 1'b1);
      repeat (3) send_cmd(CMD_TICK, 1'b0);
      // run off: keeps toggling until back at idle, then the count runs on
      send_cmd(CMD_RUN, 1'b0);
      repeat (2) send_cmd(CMD_TICK, 1'b0);
      send_cmd(CMD_WRITE, 1'b1);
      send_cmd(CMD_TRIGGER, 1'b1);
      send_cmd(CMD_TICK, 1'b0);
   endtask

   task automatic test_extremes();
      program_timer('1, '1, 1'b1, 1'b1);
      send_cmd(CMD_RUN, 1'b1);
      repeat (2) send_cmd(CMD_TICK, 1'b1);
      program_timer('0, '0, 1'b1, 1'b0);
      repeat (2) send_cmd(CMD_TICK, 1'b0);
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 11; phase++) begin
         program_timer(random_period(), random_period(),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
         calm = (phase == 4);
         for (int n = 0; n < 94; n++) begin
            if (phase == 6 && n == 47) wait_drained();
            send_random_cmd();
         end
         calm = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   always @(posedge clock) begin
      pin_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pins.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat tdata=%h", rsp_tdata));
         end else begin
            want = pending_pins.pop_front();
            if (rsp_tdata[0] !== want.pin_level)
               flag_mismatch($sformatf("pin_level %b, want %b", rsp_tdata[0], want.pin_level));
            if (rsp_tdata[1] !== want.changed)
               flag_mismatch($sformatf("changed %b, want %b", rsp_tdata[1], want.changed));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("timeout: no beat for %0d cycles", StallLimit);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      calm         = 1'b0;
      mismatches   = 0;
      timer_cfg    = '0;
      timer_st     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_one_shot();
      test_continuous();
      test_extremes();
      test_random();

      wait_drained();
      if (pending_pins.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_pins.size()));
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ptt_pkg.sv
rtl/core/ptt_csr.sv
rtl/core/ptt_step.sv
rtl/core/pulse_trigger_timer.sv
test/tb_pulse_trigger_timer.sv
